/* hw/rtl/bffa_pkg.sv */
// Shared types and constants of the bitmap first-free block allocator.
package bffa_pkg;

  localparam int unsigned MaxBlocksDefault = 8192;
  localparam int unsigned WordBitsDefault  = 32;
  localparam int unsigned CntW             = 14;

  localparam logic [CntW-1:0] ActiveBlocksReset = 14'd8192;

  localparam logic [1:0] OpLoad  = 2'd0;
  localparam logic [1:0] OpAlloc = 2'd1;
  localparam logic [1:0] OpSet   = 2'd2;

  localparam logic StatusOk   = 1'b0;
  localparam logic StatusFull = 1'b1;

  typedef struct packed {
    logic [1:0]      operation;
    logic [7:0]      word_index;
    logic [31:0]     word_data;
    logic [CntW-1:0] free_count_value;
  } req_t;

  typedef struct packed {
    logic [CntW-1:0] block_number;
    logic            status;
    logic [CntW-1:0] free_count;
  } rsp_t;

  typedef struct packed {
    logic found;
    logic last;
  } scan_flags_t;

endpackage

/* hw/rtl/bitmap_first_free_allocator_unit.sv */
// Bitmap first-free block allocator: sequencer, bitmap RAM and word scanner.
// Load and set: result strobe in the cycle after the accepting edge, next command then.
// Allocate: one bitmap word per cycle through the scanner; at most MapWords
//   words are scanned (256 by default).
// Reset: a clearing pass zeroes all MapWords bitmap RAM words (256 by default)
//   one word a cycle, with busy high. Results are one-cycle strobes; no stall.
module bitmap_first_free_allocator_unit #(
  parameter int unsigned MaxBlocks = bffa_pkg::MaxBlocksDefault,
  parameter int unsigned WordBits  = bffa_pkg::WordBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  bffa_pkg::req_t                req_i,
  output logic                          result_valid_o,
  output bffa_pkg::rsp_t                rsp_o,
  input  logic                          cfg_we_i,
  input  logic [bffa_pkg::CntW-1:0]     cfg_wdata_i
);

  localparam int unsigned MapWords = (MaxBlocks + WordBits - 1) / WordBits;
  localparam int unsigned AddrW    = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int unsigned BitW     = (WordBits > 1) ? $clog2(WordBits) : 1;
  localparam int unsigned SpanW    = $clog2(MapWords * WordBits + WordBits + 1);
  localparam int unsigned BaseW    = (SpanW > bffa_pkg::CntW + 1) ? SpanW
                                                                  : bffa_pkg::CntW + 1;
  localparam int unsigned CntW     = bffa_pkg::CntW;

  typedef enum logic [2:0] {
    StClear = 3'b001,
    StIdle  = 3'b010,
    StScan  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [AddrW-1:0]    clr_q, clr_d;
  logic [AddrW-1:0]    word_q, word_d;
  logic [BaseW-1:0]    base_q, base_d;
  logic [CntW-1:0]     free_q, free_d;
  logic [CntW-1:0]     active_q;
  logic                valid_q, valid_d;
  bffa_pkg::rsp_t      rsp_q, rsp_d;

  logic                we;
  logic [AddrW-1:0]    waddr, raddr, word_next;
  logic [WordBits-1:0] wdata, rdata;
  logic [BaseW-1:0]    limit;
  logic [BitW-1:0]     hit_idx;
  bffa_pkg::scan_flags_t flags;
  logic                accept;

  bffa_ram #(
    .Width (WordBits),
    .Depth (MapWords)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bffa_scan #(
    .WordBits (WordBits),
    .BaseW    (BaseW)
  ) u_scan (
    .word_i  (rdata),
    .base_i  (base_q),
    .limit_i (limit),
    .flags_o (flags),
    .idx_o   (hit_idx)
  );

  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;
  assign limit  = (BaseW'(active_q) < BaseW'(MaxBlocks)) ? BaseW'(active_q)
                                                         : BaseW'(MaxBlocks);
  assign word_next = (word_q == AddrW'(MapWords - 1)) ? '0 : word_q + AddrW'(1);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    word_d  = word_q;
    base_d  = base_q;
    free_d  = free_q;
    valid_d = 1'b0;
    rsp_d   = rsp_q;
    we      = 1'b0;
    waddr   = word_q;
    wdata   = rdata | (WordBits'(1) << hit_idx);
    raddr   = '0;
    unique case (state_q)
      StClear: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + AddrW'(1);
        if (clr_q == AddrW'(MapWords - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          rsp_d.block_number = '0;
          rsp_d.status       = bffa_pkg::StatusOk;
          priority if (req_i.operation == bffa_pkg::OpLoad) begin
            we    = (32'(req_i.word_index) < MapWords);
            waddr = AddrW'(req_i.word_index);
            wdata = WordBits'(req_i.word_data);
            rsp_d.free_count = free_q;
            valid_d = 1'b1;
          end else if (req_i.operation == bffa_pkg::OpSet) begin
            free_d = req_i.free_count_value;
            rsp_d.free_count = req_i.free_count_value;
            valid_d = 1'b1;
          end else if (req_i.operation == bffa_pkg::OpAlloc) begin
            word_d  = '0;
            base_d  = '0;
            state_d = StScan;
          end else begin
            rsp_d.free_count = free_q;
            valid_d = 1'b1;
          end
        end
      end
      StScan: begin
        raddr = word_next;
        if (flags.found) begin
          we     = 1'b1;
          free_d = (free_q != '0) ? free_q - CntW'(1) : free_q;
          rsp_d.block_number = CntW'(base_q + BaseW'(hit_idx) + BaseW'(1));
          rsp_d.status       = bffa_pkg::StatusOk;
          rsp_d.free_count   = (free_q != '0) ? free_q - CntW'(1) : free_q;
          valid_d = 1'b1;
          state_d = StIdle;
        end else if (flags.last) begin
          rsp_d.block_number = '0;
          rsp_d.status       = bffa_pkg::StatusFull;
          rsp_d.free_count   = free_q;
          valid_d = 1'b1;
          state_d = StIdle;
        end else begin
          word_d = word_next;
          base_d = base_q + BaseW'(WordBits);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClear;
      clr_q    <= '0;
      word_q   <= '0;
      base_q   <= '0;
      free_q   <= '0;
      active_q <= bffa_pkg::ActiveBlocksReset;
      valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      word_q  <= word_d;
      base_q  <= base_d;
      free_q  <= free_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign result_valid_o = valid_q;
  assign rsp_o          = rsp_q;

endmodule

/* hw/rtl/bffa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bffa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/bffa_scan.sv */
// Word scanner: lowest free bit of one bitmap word below the search limit.
module bffa_scan #(
  parameter int unsigned WordBits = bffa_pkg::WordBitsDefault,
  parameter int unsigned BaseW    = 15,
  localparam int unsigned BitW    = (WordBits > 1) ? $clog2(WordBits) : 1
) (
  input  logic [WordBits-1:0]  word_i,
  input  logic [BaseW-1:0]     base_i,
  input  logic [BaseW-1:0]     limit_i,
  output bffa_pkg::scan_flags_t flags_o,
  output logic [BitW-1:0]      idx_o
);

  logic [BaseW-1:0] rem;

  always_comb begin
    rem = (limit_i > base_i) ? (limit_i - base_i) : '0;
    flags_o.found = 1'b0;
    idx_o         = '0;
    for (int k = WordBits - 1; k >= 0; k--) begin
      if (!word_i[k] && (BaseW'(k) < rem)) begin
        flags_o.found = 1'b1;
        idx_o         = BitW'(k);
      end
    end
    flags_o.last = (base_i + BaseW'(WordBits)) >= limit_i;
  end

endmodule
